FILE: rtl/core/mm_pkg.sv
// ----------------------------------------------------------------------------
// mm_pkg
// Shared types and constants of the matrix multiply block.
// ----------------------------------------------------------------------------
package mm_pkg;

  localparam int unsigned DimW  = 4;
  localparam int unsigned IdxW  = 3;
  localparam int unsigned DataW = 32;
  localparam int unsigned AccW  = 64;

  typedef enum logic [1:0] {
    OP_WRITE_A = 2'd0,
    OP_WRITE_B = 2'd1,
    OP_COMPUTE = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    REG_ROWS_A = 2'd0,
    REG_COLS_A = 2'd1,
    REG_ROWS_B = 2'd2,
    REG_COLS_B = 2'd3
  } reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_RUN,
    ST_DRAIN
  } state_e;

  // Control handed from the sequencer to the cell chain.
  typedef struct packed {
    logic clear;
    logic enable;
  } cell_ctrl_t;

endpackage

FILE: rtl/core/mm_cell.sv
// ----------------------------------------------------------------------------
// mm_cell
// One multiply-accumulate cell: registered product, scaled, then accumulated.
// Restart the sum on the first term of each dot product.
// Passes its A operand on to its neighbor every cycle.
// ----------------------------------------------------------------------------
module mm_cell #(
  parameter int unsigned FracBits = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  mm_pkg::cell_ctrl_t               ctrl_i,
  input  logic                             a_valid_i,
  input  logic                             first_i,
  input  logic signed [mm_pkg::DataW-1:0]  a_i,
  input  logic signed [mm_pkg::DataW-1:0]  b_i,
  output logic                             a_valid_o,
  output logic signed [mm_pkg::DataW-1:0]  a_o,
  output logic signed [mm_pkg::AccW-1:0]   acc_o
);

  logic signed [mm_pkg::AccW-1:0] prod_q;
  logic                           prod_vld_q;
  logic                           prod_first_q;
  logic signed [mm_pkg::AccW-1:0] acc_q, acc_d;
  logic signed [mm_pkg::DataW-1:0] a_q;
  logic                           a_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      a_vld_q    <= 1'b0;
      acc_q      <= '0;
    end else begin
      prod_vld_q <= a_valid_i & ctrl_i.enable;
      a_vld_q    <= a_valid_i & ctrl_i.enable;
      acc_q      <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q       <= a_i * b_i;
    prod_first_q <= first_i;
    a_q          <= a_i;
  end

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (prod_vld_q && prod_first_q) begin
      acc_d = prod_q >>> FracBits;
    end else if (prod_vld_q) begin
      acc_d = acc_q + (prod_q >>> FracBits);
    end
  end

  assign a_valid_o = a_vld_q;
  assign a_o       = a_q;
  assign acc_o     = acc_q;

endmodule

FILE: rtl/core/matrix_multiply.sv
// ----------------------------------------------------------------------------
// matrix_multiply
// A write goes into its store when it is accepted. A compute fetches the A
// elements of one product row into the chain (ST_FETCH), waits in ST_RUN,
// then emits cols_b results on consecutive cycles (ST_DRAIN). A row of
// MaxDim cells works one product row at a time, fed one A element a cycle while fetching.
// Busy stays high until the last row is out, so no new command is accepted
// meanwhile; busy drops in the cycle of the last result strobe.
// Reset clears control and sets every dimension to 8; stores stay undefined.
// The receiver cannot stall: each result strobe lasts one cycle.
// ----------------------------------------------------------------------------
module matrix_multiply #(
  parameter int unsigned MaxDim   = 8,
  parameter int unsigned FracBits = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      operation_i,
  input  logic [mm_pkg::IdxW-1:0]         row_i,
  input  logic [mm_pkg::IdxW-1:0]         col_i,
  input  logic signed [mm_pkg::DataW-1:0] value_i,
  input  logic                            cfg_we_i,
  input  logic [1:0]                      cfg_idx_i,
  input  logic [mm_pkg::DimW-1:0]         cfg_data_i,
  output logic                            out_strobe_o,
  output logic [mm_pkg::IdxW-1:0]         out_row_o,
  output logic [mm_pkg::IdxW-1:0]         out_col_o,
  output logic signed [mm_pkg::DataW-1:0] out_value_o,
  output logic                            last_o,
  output logic                            dim_error_o
);

  localparam int unsigned KW = (MaxDim > 1) ? $clog2(MaxDim) : 1;
  localparam int unsigned CW = $clog2(MaxDim + 1);

  logic [mm_pkg::DimW-1:0] rows_a_q, cols_a_q, rows_b_q, cols_b_q;
  logic [CW-1:0] ra, ca, rb, cb;

  function automatic logic [CW-1:0] clamp_dim(input logic [mm_pkg::DimW-1:0] v);
    logic [CW-1:0] r;
    if (v == '0) r = CW'(1);
    else if (32'(v) > MaxDim) r = CW'(MaxDim);
    else r = CW'(v);
    return r;
  endfunction

  assign ra = clamp_dim(rows_a_q);
  assign ca = clamp_dim(cols_a_q);
  assign rb = clamp_dim(rows_b_q);
  assign cb = clamp_dim(cols_b_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q <= mm_pkg::DimW'(8);
      cols_a_q <= mm_pkg::DimW'(8);
      rows_b_q <= mm_pkg::DimW'(8);
      cols_b_q <= mm_pkg::DimW'(8);
    end else if (cfg_we_i) begin
      unique case (mm_pkg::reg_e'(cfg_idx_i))
        mm_pkg::REG_ROWS_A: rows_a_q <= cfg_data_i;
        mm_pkg::REG_COLS_A: cols_a_q <= cfg_data_i;
        mm_pkg::REG_ROWS_B: rows_b_q <= cfg_data_i;
        mm_pkg::REG_COLS_B: cols_b_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A store: one read port feeding the chain. B is held per cell column.
  logic [mm_pkg::DataW-1:0] a_mem [MaxDim][MaxDim];
  logic [mm_pkg::DataW-1:0] b_mem [MaxDim][MaxDim];
  logic [mm_pkg::DataW-1:0] a_rd_q;

  logic accept, wr_ok;
  assign accept = start & ~busy;
  assign wr_ok  = (32'(row_i) < MaxDim) && (32'(col_i) < MaxDim);

  // Sequencer.
  mm_pkg::state_e state_q, state_d;
  logic [KW-1:0] i_q, i_d, k_q, k_d, j_q, j_d;
  logic [CW:0]   cnt_q, cnt_d;
  logic          err_q, err_d;
  logic          rd_vld_q, rd_vld_d;
  mm_pkg::cell_ctrl_t ctrl;
  logic [KW-1:0] kb_q;

  always_ff @(posedge clk_i) begin
    if (accept && wr_ok && operation_i == mm_pkg::OP_WRITE_A) begin
      a_mem[KW'(row_i)][KW'(col_i)] <= value_i;
    end
    a_rd_q <= a_mem[i_q][k_q];
  end

  always_ff @(posedge clk_i) begin
    if (accept && wr_ok && operation_i == mm_pkg::OP_WRITE_B) begin
      b_mem[KW'(row_i)][KW'(col_i)] <= value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= mm_pkg::ST_IDLE;
      i_q      <= '0;
      k_q      <= '0;
      j_q      <= '0;
      cnt_q    <= '0;
      err_q    <= 1'b0;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      i_q      <= i_d;
      k_q      <= k_d;
      j_q      <= j_d;
      cnt_q    <= cnt_d;
      err_q    <= err_d;
      rd_vld_q <= rd_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kb_q <= k_q;
  end

  logic emit;
  always_comb begin
    state_d  = state_q;
    i_d      = i_q;
    k_d      = k_q;
    j_d      = j_q;
    cnt_d    = cnt_q;
    err_d    = err_q;
    rd_vld_d = 1'b0;
    ctrl     = '{clear: 1'b0, enable: 1'b1};
    emit     = 1'b0;
    busy     = 1'b1;
    unique case (state_q)
      mm_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (accept && operation_i == mm_pkg::OP_COMPUTE) begin
          state_d = mm_pkg::ST_FETCH;
          i_d     = '0;
          k_d     = '0;
          err_d   = (ca != rb);
          ctrl.clear = 1'b1;
        end
      end
      mm_pkg::ST_FETCH: begin
        rd_vld_d = ~err_q;
        if ({1'b0, k_q} == CW'(ca - CW'(1))) begin
          k_d     = '0;
          cnt_d   = '0;
          state_d = mm_pkg::ST_RUN;
        end else begin
          k_d = k_q + KW'(1);
        end
      end
      mm_pkg::ST_RUN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == (CW+1)'(3)) begin
          j_d     = '0;
          state_d = mm_pkg::ST_DRAIN;
        end
      end
      mm_pkg::ST_DRAIN: begin
        emit = 1'b1;
        if ({1'b0, j_q} == CW'(cb - CW'(1))) begin
          ctrl.clear = 1'b1;
          if ({1'b0, i_q} == CW'(ra - CW'(1))) begin
            state_d = mm_pkg::ST_IDLE;
          end else begin
            i_d     = i_q + KW'(1);
            state_d = mm_pkg::ST_FETCH;
          end
        end else begin
          j_d = j_q + KW'(1);
        end
      end
      default: state_d = mm_pkg::ST_IDLE;
    endcase
  end

  // Chain of cells: A element with its k index travels down the row; each
  // cell j takes B[k][j] for the k it currently sees.
  logic                           vld_c [MaxDim+1];
  logic signed [mm_pkg::DataW-1:0] a_c  [MaxDim+1];
  logic [KW-1:0]                  k_c  [MaxDim+1];
  logic signed [mm_pkg::AccW-1:0] acc_c [MaxDim];

  assign vld_c[0] = rd_vld_q;
  assign a_c[0]   = a_rd_q;
  assign k_c[0]   = kb_q;

  for (genvar g = 0; g < MaxDim; g++) begin : g_cell
    logic [KW-1:0] k_q2;
    always_ff @(posedge clk_i) begin
      k_q2 <= k_c[g];
    end
    assign k_c[g+1] = k_q2;
    mm_cell #(.FracBits(FracBits)) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .a_valid_i (vld_c[g]),
      .first_i   (k_c[g] == '0),
      .a_i       (a_c[g]),
      .b_i       (b_mem[k_c[g]][g]),
      .a_valid_o (vld_c[g+1]),
      .a_o       (a_c[g+1]),
      .acc_o     (acc_c[g])
    );
  end

  // Output register.
  logic signed [mm_pkg::AccW-1:0] sel;
  assign sel = acc_c[j_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_strobe_o <= 1'b0;
    end else begin
      out_strobe_o <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    out_row_o   <= mm_pkg::IdxW'(i_q);
    out_col_o   <= mm_pkg::IdxW'(j_q);
    last_o      <= ({1'b0, i_q} == CW'(ra - CW'(1))) && ({1'b0, j_q} == CW'(cb - CW'(1)));
    dim_error_o <= err_q;
    if (err_q) begin
      out_value_o <= '0;
    end else if (sel > 64'sh7FFF_FFFF) begin
      out_value_o <= 32'sh7FFF_FFFF;
    end else if (sel < -64'sh8000_0000) begin
      out_value_o <= 32'sh8000_0000;
    end else begin
      out_value_o <= sel[mm_pkg::DataW-1:0];
    end
  end

endmodule

FILE: tb/matrix_multiply_tb.sv
// ----------------------------------------------------------------------------
// matrix_multiply_tb
// Drives element writes and compute commands through several dimension
// settings and sender idle rates, predicts every product element in fixed
// point and checks each result transaction in order.
// ----------------------------------------------------------------------------
module matrix_multiply_tb;
  import mm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Dim      = 8;
  localparam int unsigned Frac     = 16;
  localparam int unsigned Settle   = 200;
  localparam int unsigned Watchdog = 5000;

  typedef struct packed {
    op_e              op;
    logic [IdxW-1:0]  row;
    logic [IdxW-1:0]  col;
    logic [DataW-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [IdxW-1:0]  row;
    logic [IdxW-1:0]  col;
    logic [DataW-1:0] value;
    logic             last;
    logic             err;
  } elem_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     start;
  logic                     busy;
  logic [1:0]               operation_i;
  logic [IdxW-1:0]          row_i;
  logic [IdxW-1:0]          col_i;
  logic signed [DataW-1:0]  value_i;
  logic                     cfg_we_i;
  logic [1:0]               cfg_idx_i;
  logic [DimW-1:0]          cfg_data_i;
  logic                     out_strobe_o;
  logic [IdxW-1:0]          out_row_o;
  logic [IdxW-1:0]          out_col_o;
  logic signed [DataW-1:0]  out_value_o;
  logic                     last_o;
  logic                     dim_error_o;

  cmd_t             cmd_queue[$];
  elem_t            product_queue[$];
  logic [DataW-1:0] a_mirror[Dim*Dim];
  logic [DataW-1:0] b_mirror[Dim*Dim];
  logic [DimW-1:0]  dims[4];
  logic [DimW-1:0]  gen_dims[4];
  logic [Dim*Dim-1:0] a_written;
  logic [Dim*Dim-1:0] b_written;
  int unsigned      idle_pct;
  int unsigned      mismatches;
  int unsigned      quiet_cycles;

  matrix_multiply i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .operation_i  (operation_i),
    .row_i        (row_i),
    .col_i        (col_i),
    .value_i      (value_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .out_strobe_o (out_strobe_o),
    .out_row_o    (out_row_o),
    .out_col_o    (out_col_o),
    .out_value_o  (out_value_o),
    .last_o       (last_o),
    .dim_error_o  (dim_error_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned clamp_dim(logic [DimW-1:0] v);
    if (v == 0) return 1;
    if (v > Dim) return Dim;
    return v;
  endfunction

  function automatic logic [DataW-1:0] saturate(longint acc);
    if (acc > longint'(32'sh7FFF_FFFF)) return 32'h7FFF_FFFF;
    if (acc < -longint'(64'sh8000_0000)) return 32'h8000_0000;
    return acc[DataW-1:0];
  endfunction

  task automatic predict_product();
    int unsigned ra, ca, rb, cb;
    logic err;
    longint acc, x, y, p;
    elem_t e;
    ra  = clamp_dim(dims[REG_ROWS_A]);
    ca  = clamp_dim(dims[REG_COLS_A]);
    rb  = clamp_dim(dims[REG_ROWS_B]);
    cb  = clamp_dim(dims[REG_COLS_B]);
    err = (ca != rb);
    for (int i = 0; i < ra; i++) begin
      for (int j = 0; j < cb; j++) begin
        acc = 0;
        if (!err) begin
          for (int k = 0; k < ca; k++) begin
            x = longint'($signed(a_mirror[i*Dim+k]));
            y = longint'($signed(b_mirror[k*Dim+j]));
            p = x * y;
            acc += (p >>> Frac);
          end
        end
        e.row   = i[IdxW-1:0];
        e.col   = j[IdxW-1:0];
        e.value = err ? '0 : saturate(acc);
        e.last  = (i == ra - 1) && (j == cb - 1);
        e.err   = err;
        product_queue.push_back(e);
      end
    end
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    cmd_t c;
    if (!rst_ni) begin
      start       <= 1'b0;
      operation_i <= OP_NONE;
      row_i       <= '0;
      col_i       <= '0;
      value_i     <= '0;
    end else if (!start || !busy) begin
      if (cmd_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
        c = cmd_queue.pop_front();
        start       <= 1'b1;
        operation_i <= c.op;
        row_i       <= c.row;
        col_i       <= c.col;
        value_i     <= c.value;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor and predictor
  always @(posedge clk_i or negedge rst_ni) begin
    elem_t e;
    if (!rst_ni) begin
      for (int r = 0; r < 4; r++) dims[r] <= 4'd8;
      quiet_cycles <= 0;
    end else begin
      if (cfg_we_i) dims[cfg_idx_i] <= cfg_data_i;
      if (start && !busy) begin
        case (op_e'(operation_i))
          OP_WRITE_A: a_mirror[row_i*Dim+col_i] = value_i;
          OP_WRITE_B: b_mirror[row_i*Dim+col_i] = value_i;
          OP_COMPUTE: predict_product();
          default: ;
        endcase
      end
      if (out_strobe_o) begin
        if (product_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result row %0d col %0d value %h", out_row_o, out_col_o,
                     out_value_o);
        end else begin
          e = product_queue.pop_front();
          if (out_row_o !== e.row || out_col_o !== e.col || out_value_o !== e.value ||
              last_o !== e.last || dim_error_o !== e.err) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch exp r%0d c%0d v%h l%b e%b got r%0d c%0d v%h l%b e%b",
                       e.row, e.col, e.value, e.last, e.err, out_row_o, out_col_o,
                       out_value_o, last_o, dim_error_o);
          end
        end
      end
      if ((start && !busy) || out_strobe_o || cfg_we_i) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= Watchdog) begin
        $display("matrix_multiply_tb: errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic push_cmd(op_e op, int unsigned r, int unsigned c, logic [DataW-1:0] v);
    cmd_t cm;
    cm.op    = op;
    cm.row   = r[IdxW-1:0];
    cm.col   = c[IdxW-1:0];
    cm.value = v;
    cmd_queue.push_back(cm);
    if (op == OP_WRITE_A) a_written[r*Dim+c] = 1'b1;
    if (op == OP_WRITE_B) b_written[r*Dim+c] = 1'b1;
  endtask

  function automatic logic [DataW-1:0] rand_value();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 25) return $urandom;
    if (sel < 30) return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    return 32'($signed($urandom_range(8 << Frac)) - (4 << Frac));
  endfunction

  task automatic write_cfg(reg_e idx, logic [DimW-1:0] v);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    gen_dims[idx] = v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_idle();
    while (cmd_queue.size() > 0 || product_queue.size() > 0 || start || busy)
      @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
  endtask

  // if ca == rb, write unset and some random A/B elements, then a compute
  task automatic push_product();
    int unsigned ra, ca, rb, cb;
    ra = clamp_dim(gen_dims[REG_ROWS_A]);
    ca = clamp_dim(gen_dims[REG_COLS_A]);
    rb = clamp_dim(gen_dims[REG_ROWS_B]);
    cb = clamp_dim(gen_dims[REG_COLS_B]);
    if (ca == rb) begin
      for (int i = 0; i < ra; i++)
        for (int k = 0; k < ca; k++)
          if (!a_written[i*Dim+k] || $urandom_range(9) == 0)
            push_cmd(OP_WRITE_A, i, k, rand_value());
      for (int k = 0; k < ca; k++)
        for (int j = 0; j < cb; j++)
          if (!b_written[k*Dim+j] || $urandom_range(9) == 0)
            push_cmd(OP_WRITE_B, k, j, rand_value());
    end
    push_cmd(OP_COMPUTE, 0, 0, $urandom);
  endtask

  task automatic run_random(int unsigned count);
    int unsigned sel, start_len;
    start_len = cmd_queue.size();
    while (cmd_queue.size() - start_len < count) begin
      sel = $urandom_range(99);
      if (sel < 8) push_cmd(OP_NONE, $urandom_range(7), $urandom_range(7), $urandom);
      else if (sel < 30)
        push_cmd(op_e'($urandom_range(1)), $urandom_range(7), $urandom_range(7), rand_value());
      else push_product();
    end
  endtask

  task automatic run_phase(int unsigned pct, logic [DimW-1:0] ra, logic [DimW-1:0] ca,
                           logic [DimW-1:0] rb, logic [DimW-1:0] cb, int unsigned count);
    wait_idle();
    idle_pct = pct;
    write_cfg(REG_ROWS_A, ra);
    write_cfg(REG_COLS_A, ca);
    write_cfg(REG_ROWS_B, rb);
    write_cfg(REG_COLS_B, cb);
    run_random(count);
  endtask

  initial begin
    a_written   = '0;
    b_written   = '0;
    mismatches  = 0;
    idle_pct    = 0;
    for (int r = 0; r < 4; r++) gen_dims[r] = 4'd8;
    for (int r = 0; r < Dim*Dim; r++) begin
      a_mirror[r] = '0;
      b_mirror[r] = '0;
    end
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= REG_ROWS_A;
    cfg_data_i <= '0;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_cfg(REG_ROWS_A, 4'd2);
    write_cfg(REG_COLS_A, 4'd2);
    write_cfg(REG_ROWS_B, 4'd2);
    write_cfg(REG_COLS_B, 4'd2);
    push_cmd(OP_WRITE_A, 0, 0, 32'h7FFF_FFFF);
    push_cmd(OP_WRITE_A, 0, 1, 32'h7FFF_FFFF);
    push_cmd(OP_WRITE_A, 1, 0, 32'h8000_0000);
    push_cmd(OP_WRITE_A, 1, 1, 32'hFFFF_FFFF);
    push_cmd(OP_WRITE_B, 0, 0, 32'h7FFF_FFFF);
    push_cmd(OP_WRITE_B, 0, 1, 32'h8000_0000);
    push_cmd(OP_WRITE_B, 1, 0, 32'h0000_0001);
    push_cmd(OP_WRITE_B, 1, 1, 32'hFFFF_FFFF);
    push_cmd(OP_COMPUTE, 7, 7, 32'hFFFF_FFFF);
    push_cmd(OP_WRITE_A, 7, 7, 32'hFFFF_FFFF);
    push_cmd(OP_WRITE_B, 7, 7, 32'h0000_0000);
    push_cmd(OP_NONE, 7, 7, 32'hFFFF_FFFF);
    push_cmd(OP_WRITE_A, 0, 0, 32'h0001_0000);
    push_cmd(OP_WRITE_A, 0, 1, 32'hFFFF_0000);
    push_cmd(OP_WRITE_A, 1, 0, 32'h0000_8000);
    push_cmd(OP_WRITE_A, 1, 1, 32'hFFFF_FFFF);
    push_cmd(OP_COMPUTE, 0, 0, 32'h0000_0000);
    run_random(80);

    run_phase(67, 4'd0, 4'd0, 4'd0, 4'd15, 60);
    run_phase(0, 4'd8, 4'd8, 4'd8, 4'd8, 90);
    run_phase(35, 4'd3, 4'd5, 4'd4, 4'd2, 50);
    run_phase(67, 4'd15, 4'd9, 4'd8, 4'd1, 60);
    run_phase(35, 4'd4, 4'd3, 4'd3, 4'd6, 60);

    while (cmd_queue.size() > 0 || product_queue.size() > 0) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
    if (mismatches == 0 && product_queue.size() == 0) begin
      $display("matrix_multiply_tb: clean");
    end else begin
      $display("matrix_multiply_tb: errors");
    end
    $finish;
  end

endmodule
